@@ rtl/rsvg_pkg.sv @@
// Shared types, widths and constants for the ring segment vertex generator.
// Used by rsvg_div, rsvg_cordic and ring_segment_vertex_generator_top.
`timescale 1ns / 1ps

package rsvg_pkg;

    // Field and register widths
    localparam int IDX_W     = 12;
    localparam int DIV_W     = 13;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 17;
    localparam int U_W       = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_DIVISIONS     = 4096;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Divider: dividend is pos * 2^32, quotient fits 33 bits
    localparam int PHASE_W         = 32;
    localparam int DVD_W           = DIV_W + PHASE_W;
    localparam int QUO_W           = PHASE_W + 1;
    localparam int STEPS_PER_STAGE = 5;
    localparam int DIV_STAGES      = (DVD_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // CORDIC datapath
    localparam int CORDIC_ITER    = (CORDIC_ITERATIONS > ATAN_ENTRIES) ?
                                    ATAN_ENTRIES : CORDIC_ITERATIONS;
    localparam int ITER_PER_STAGE = 2;
    localparam int CORDIC_STAGES  = (CORDIC_ITER + ITER_PER_STAGE - 1) / ITER_PER_STAGE;
    localparam int XY_W           = 34;
    localparam int Z_W            = 33;
    localparam int TRIG_W         = 16;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032875;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_DIVISIONS = 2'd1,
        ERR_RADII     = 2'd2,
        ERR_INDEX     = 2'd3
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVISIONS = 2'd0,
        REG_OUTER     = 2'd1,
        REG_INNER     = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    // Sideband that travels with each corner beat through the pipeline
    typedef struct packed {
        logic           valid;
        logic [1:0]     corner;
        err_t           err;
        logic [U_W-1:0] tex_u;
    } beat_tag_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turns(input int i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2608;
            19: a = 33'sd1304;
            20: a = 33'sd652;
            21: a = 33'sd326;
            22: a = 33'sd163;
            23: a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/ring_segment_vertex_generator_top.sv @@
// Top level of the ring segment vertex generator: corner sequencing, scaling, output.
// Depends on rsvg_pkg, rsvg_div and rsvg_cordic.
`timescale 1ns / 1ps

// Usage
//   Input channel: segment_index with in_valid / in_stall. Each accepted index
//   expands into four corner beats (outer start, outer end, inner start,
//   inner end) or into a single error beat with last set.
//   Output channel: pos_x, pos_y, tex_u, tex_v, corner, last, error_code with
//   out_valid / out_stall.
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//   divisions above 4096 act as 4096; swapped radii are put in order.
// Pipeline: 22 register stages (10 divider, 10 CORDIC, 1 multiply, 1 output),
//   the first loaded at the accepting edge itself.
// Throughput: one corner beat per cycle unless out_stall freezes the pipeline,
//   set by the corner sequencer feeding a single fully pipelined datapath;
//   no new index is taken mid-item; an error index yields its single beat.
// Reset: all valid bits clear, registers return to 32 divisions, outer
//   radius 1.0, inner radius 0.5.
// Stall: while out_stall holds a waiting beat the whole pipeline freezes and
//   in_stall rises; nothing is dropped or repeated.
module ring_segment_vertex_generator_top
    import rsvg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        segment_index,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic [U_W-1:0]          tex_u,
    output logic                    tex_v,
    output logic [1:0]              corner,
    output logic                    last,
    output logic [1:0]              error_code
);

    logic [DIV_W-1:0]   divisions_reg;
    logic [RAD_W-1:0]   outer_reg;
    logic [RAD_W-1:0]   inner_reg;

    logic [DIV_W-1:0]   div_sat;
    logic [RAD_W-1:0]   r_out;
    logic [RAD_W-1:0]   r_in;

    logic               en;
    logic               start;
    err_t               in_err;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic [IDX_W-1:0]   idx_reg;

    beat_tag_t          beat_tag;
    logic [DIV_W-1:0]   beat_pos;

    beat_tag_t          div_tag;
    logic [PHASE_W-1:0] div_phase;
    beat_tag_t          trig_tag;
    logic signed [TRIG_W-1:0] trig_sin;
    logic signed [TRIG_W-1:0] trig_cos;

    logic signed [POS_W-1:0]   rad_s;
    logic signed [POS_W-1:0]   nsin;
    beat_tag_t                 mul_tag_reg;
    logic signed [2*POS_W-1:0] prod_x_reg;
    logic signed [2*POS_W-1:0] prod_y_reg;
    logic signed [2*POS_W-1:0] rnd_x;
    logic signed [2*POS_W-1:0] rnd_y;

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;
    logic [U_W-1:0]          tex_u_reg;
    logic                    tex_v_reg;
    logic [1:0]              corner_reg;
    logic                    last_reg;
    err_t                    err_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= DIV_W'(32);
            outer_reg     <= RAD_W'(256);
            inner_reg     <= RAD_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIVISIONS: divisions_reg <= cfg_data[DIV_W-1:0];
                REG_OUTER:     outer_reg     <= cfg_data;
                REG_INNER:     inner_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Clamp divisions and order the radii
    assign div_sat = (divisions_reg > DIV_W'(MAX_DIVISIONS)) ?
                     DIV_W'(MAX_DIVISIONS) : divisions_reg;
    assign r_out   = (outer_reg < inner_reg) ? inner_reg : outer_reg;
    assign r_in    = (outer_reg < inner_reg) ? outer_reg : inner_reg;

    // Whole pipeline moves unless a beat waits on a stalled output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en || (cnt_reg != 2'd0);
    assign start    = in_valid && !in_stall;

    // Classify the index, first failing check wins
    always_comb
    begin
        priority if (div_sat < DIV_W'(3))
            in_err = ERR_DIVISIONS;
        else if (r_out == r_in)
            in_err = ERR_RADII;
        else if ({1'b0, segment_index} >= div_sat)
            in_err = ERR_INDEX;
        else
            in_err = ERR_NONE;
    end

    // Corner sequencer: first beat straight from the input, then three held
    always_comb
    begin
        beat_tag = '0;
        if (cnt_reg == 2'd0)
        begin
            beat_tag.valid = start;
            beat_tag.err   = in_err;
            beat_pos       = {1'b0, segment_index};
        end
        else
        begin
            beat_tag.valid  = 1'b1;
            beat_tag.corner = cnt_reg;
            beat_pos        = {1'b0, idx_reg} + DIV_W'(cnt_reg[0]);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (en)
        begin
            if (cnt_reg != 2'd0)
                cnt_next = cnt_reg + 2'd1;
            else if (start && in_err == ERR_NONE)
                cnt_next = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= segment_index;
        end
    end

    rsvg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_tag    (beat_tag),
        .in_pos    (beat_pos),
        .div       (div_sat),
        .out_tag   (div_tag),
        .out_phase (div_phase)
    );

    rsvg_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (div_tag),
        .in_phase (div_phase),
        .out_tag  (trig_tag),
        .out_sin  (trig_sin),
        .out_cos  (trig_cos)
    );

    // Scale by the radius of this edge
    assign rad_s = signed'({1'b0, (trig_tag.corner[1] ? r_in : r_out)});
    assign nsin  = -POS_W'(trig_sin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_tag_reg <= '0;
        end
        else if (en)
        begin
            mul_tag_reg <= trig_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= nsin * rad_s;
            prod_y_reg <= POS_W'(trig_cos) * rad_s;
        end
    end

    // Round half up by 15 bits
    assign rnd_x = (prod_x_reg + (2*POS_W)'(1 <<< 14)) >>> 15;
    assign rnd_y = (prod_y_reg + (2*POS_W)'(1 <<< 14)) >>> 15;

    // Output register; error beats carry zeros and last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (mul_tag_reg.err != ERR_NONE)
            begin
                pos_x_reg  <= '0;
                pos_y_reg  <= '0;
                tex_u_reg  <= '0;
                tex_v_reg  <= 1'b0;
                corner_reg <= 2'd0;
                last_reg   <= 1'b1;
            end
            else
            begin
                pos_x_reg  <= rnd_x[POS_W-1:0];
                pos_y_reg  <= rnd_y[POS_W-1:0];
                tex_u_reg  <= mul_tag_reg.tex_u;
                tex_v_reg  <= mul_tag_reg.corner[1];
                corner_reg <= mul_tag_reg.corner;
                last_reg   <= (mul_tag_reg.corner == 2'd3);
            end
            err_reg <= mul_tag_reg.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign tex_u      = tex_u_reg;
    assign tex_v      = tex_v_reg;
    assign corner     = corner_reg;
    assign last       = last_reg;
    assign error_code = err_reg;

    // Checks
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> corner == 2'd3 || error_code != ERR_NONE)
        else $error("last on a beat that does not end an item");

    a_error_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
            pos_x == '0 && pos_y == '0 && tex_u == '0 && last)
        else $error("error beat carries vertex data");

    a_u_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tex_u <= U_W'(65536))
        else $error("texture u beyond one");

    a_no_intake_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 && en |=> cnt_reg != $past(cnt_reg))
        else $error("corner sequencer failed to advance");

endmodule

@@ rtl/rsvg_div.sv @@
// Pipelined restoring divider: pos * 2^32 / divisions, giving angle and texture u.
// Depends on rsvg_pkg.
`timescale 1ns / 1ps

module rsvg_div
    import rsvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  beat_tag_t            in_tag,
    input  logic [DIV_W-1:0]     in_pos,
    input  logic [DIV_W-1:0]     div,
    output beat_tag_t            out_tag,
    output logic [PHASE_W-1:0]   out_phase
);

    beat_tag_t          tag_reg [DIV_STAGES];
    logic [DIV_W-1:0]   pos_reg [DIV_STAGES];
    logic [DIV_W-1:0]   rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]   quo_reg [DIV_STAGES];

    beat_tag_t          st_tag  [DIV_STAGES];
    logic [DIV_W-1:0]   st_pos  [DIV_STAGES];
    logic [DIV_W-1:0]   st_rem  [DIV_STAGES];
    logic [QUO_W-1:0]   st_quo  [DIV_STAGES];
    logic [DIV_W-1:0]   pos_next [DIV_STAGES];
    logic [DIV_W-1:0]   rem_next [DIV_STAGES];
    logic [QUO_W-1:0]   quo_next [DIV_STAGES];

    beat_tag_t          out_tag_reg;
    beat_tag_t          out_tag_next;
    logic [PHASE_W-1:0] out_phase_reg;
    logic [U_W-1:0]     u_next;
    logic               round_bit;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        // Select stage input
        if (s == 0) begin : g_first
            assign st_tag[s] = in_tag;
            assign st_pos[s] = in_pos;
            assign st_rem[s] = '0;
            assign st_quo[s] = '0;
        end else begin : g_rest
            assign st_tag[s] = tag_reg[s-1];
            assign st_pos[s] = pos_reg[s-1];
            assign st_rem[s] = rem_reg[s-1];
            assign st_quo[s] = quo_reg[s-1];
        end

        // Run a few restoring steps, one quotient bit each
        always_comb
        begin
            logic [DIV_W-1:0] rem;
            logic [DIV_W-1:0] pos;
            logic [QUO_W-1:0] quo;
            logic [DIV_W:0]   trial;
            rem = st_rem[s];
            pos = st_pos[s];
            quo = st_quo[s];
            trial = '0;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (s * STEPS_PER_STAGE + j < DVD_W)
                begin
                    trial = {rem, pos[DIV_W-1]};
                    pos   = {pos[DIV_W-2:0], 1'b0};
                    if (trial >= {1'b0, div})
                    begin
                        rem = DIV_W'(trial - {1'b0, div});
                        quo = {quo[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem = trial[DIV_W-1:0];
                        quo = {quo[QUO_W-2:0], 1'b0};
                    end
                end
            end
            pos_next[s] = pos;
            rem_next[s] = rem;
            quo_next[s] = quo;
        end

        // Advance the stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else if (en)
            begin
                tag_reg[s] <= st_tag[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_reg[s] <= pos_next[s];
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    // Round quotient to nearest for angle and texture u
    assign round_bit = ({rem_reg[DIV_STAGES-1], 1'b0} >= {1'b0, div});
    assign u_next    = quo_reg[DIV_STAGES-1][QUO_W-1:16]
                     + U_W'(quo_reg[DIV_STAGES-1][15]);

    // Attach texture u to the tag
    always_comb
    begin
        out_tag_next       = tag_reg[DIV_STAGES-1];
        out_tag_next.tex_u = u_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (en)
        begin
            out_tag_reg <= out_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_phase_reg <= quo_reg[DIV_STAGES-1][PHASE_W-1:0] + PHASE_W'(round_bit);
        end
    end

    assign out_tag   = out_tag_reg;
    assign out_phase = out_phase_reg;

endmodule

@@ rtl/rsvg_cordic.sv @@
// Pipelined rotation CORDIC: sine and cosine in Q1.15 of an angle held in turns.
// Depends on rsvg_pkg.
`timescale 1ns / 1ps

module rsvg_cordic
    import rsvg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  beat_tag_t                  in_tag,
    input  logic [PHASE_W-1:0]         in_phase,
    output beat_tag_t                  out_tag,
    output logic signed [TRIG_W-1:0]   out_sin,
    output logic signed [TRIG_W-1:0]   out_cos
);

    beat_tag_t               tag_reg [CORDIC_STAGES+1];
    logic [1:0]              q_reg   [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  x_reg   [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  y_reg   [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]   z_reg   [CORDIC_STAGES+1];

    logic signed [XY_W-1:0]  x_next  [CORDIC_STAGES];
    logic signed [XY_W-1:0]  y_next  [CORDIC_STAGES];
    logic signed [Z_W-1:0]   z_next  [CORDIC_STAGES];

    logic [1:0]              quad;
    logic [PHASE_W-1:0]      resid;
    logic signed [XY_W-1:0]  cos_raw;
    logic signed [XY_W-1:0]  sin_raw;

    beat_tag_t               out_tag_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    // Round half up by 15 bits and clamp to +-32767
    function automatic logic signed [TRIG_W-1:0] sat_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + XY_W'(1 <<< 14)) >>> 15;
        if (r > XY_W'(32767))
            r = XY_W'(32767);
        else if (r < -XY_W'(32767))
            r = -XY_W'(32767);
        return r[TRIG_W-1:0];
    endfunction

    // Remove the nearest quadrant
    assign quad  = 2'((in_phase + PHASE_W'(32'h2000_0000)) >> 30);
    assign resid = in_phase - {quad, 30'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= quad;
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= Z_W'(signed'(resid));
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        // Rotate by a couple of micro-angles
        always_comb
        begin
            logic signed [XY_W-1:0] x;
            logic signed [XY_W-1:0] y;
            logic signed [Z_W-1:0]  z;
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            x = x_reg[k];
            y = y_reg[k];
            z = z_reg[k];
            xs = '0;
            ys = '0;
            for (int j = 0; j < ITER_PER_STAGE; j++)
            begin
                if (k * ITER_PER_STAGE + j < CORDIC_ITER)
                begin
                    xs = x >>> (k * ITER_PER_STAGE + j);
                    ys = y >>> (k * ITER_PER_STAGE + j);
                    if (z >= 0)
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_turns(k * ITER_PER_STAGE + j);
                    end
                    else
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_turns(k * ITER_PER_STAGE + j);
                    end
                end
            end
            x_next[k] = x;
            y_next[k] = y;
            z_next[k] = z;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1] <= q_reg[k];
                x_reg[k+1] <= x_next[k];
                y_reg[k+1] <= y_next[k];
                z_reg[k+1] <= z_next[k];
            end
        end
    end

    // Put the quadrant back
    always_comb
    begin
        unique case (q_reg[CORDIC_STAGES])
            2'd0:
            begin
                cos_raw = x_reg[CORDIC_STAGES];
                sin_raw = y_reg[CORDIC_STAGES];
            end
            2'd1:
            begin
                cos_raw = -y_reg[CORDIC_STAGES];
                sin_raw = x_reg[CORDIC_STAGES];
            end
            2'd2:
            begin
                cos_raw = -x_reg[CORDIC_STAGES];
                sin_raw = -y_reg[CORDIC_STAGES];
            end
            default:
            begin
                cos_raw = y_reg[CORDIC_STAGES];
                sin_raw = -x_reg[CORDIC_STAGES];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (en)
        begin
            out_tag_reg <= tag_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sat_q15(sin_raw);
            cos_reg <= sat_q15(cos_raw);
        end
    end

    assign out_tag = out_tag_reg;
    assign out_sin = sin_reg;
    assign out_cos = cos_reg;

endmodule
